// ===== rtl/core/gdd_pkg.sv =====
// gdd_pkg: shared types, constants and calendar tables for the day difference block
// no dependencies; imported by gdd_ctrl, gdd_datapath and the top level
`timescale 1ns / 1ps

package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int RES_W   = 23;
  localparam int ACC_W   = 24;
  localparam int R400_W  = 9;

  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  localparam int QUAD_CENTURY  = 400;
  localparam int FEB_MONTH     = 2;

  // floor(y / 400) is exact as (y * MOD_RECIP) >> MOD_SHIFT for every 14-bit year
  localparam int MOD_RECIP = 5243;
  localparam int MOD_SHIFT = 21;

  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(4194303);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_S,
    ST_MOD_E,
    ST_INIT,
    ST_LOOP
  } gdd_state_t;

  typedef struct packed {
    logic load;
    logic mod_s;
    logic mod_e;
    logic init;
    logic step;
    logic finish;
  } gdd_cmd_t;

  typedef struct packed {
    logic y_lt_end;
  } gdd_status_t;

  // days in all months before the given one, common year; months 13 to 15 give all 365
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/gdd_ctrl.sv =====
// gdd_ctrl: sequencer for the day difference block
// depends on gdd_pkg; drives gdd_datapath through gdd_cmd_t
`timescale 1ns / 1ps

module gdd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gdd_pkg::gdd_status_t status,
  output gdd_pkg::gdd_cmd_t    cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import gdd_pkg::*;

  gdd_state_t state_r, state_nxt;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.finish;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD_S;
        end
      end
      ST_MOD_S: begin
        cmd.mod_s = 1'b1;
        state_nxt = ST_MOD_E;
      end
      ST_MOD_E: begin
        cmd.mod_e = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (status.y_lt_end) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

// ===== rtl/core/gdd_datapath.sv =====
// gdd_datapath: year counter, mod-400 tracker, day-of-year and accumulator
// depends on gdd_pkg; commanded by gdd_ctrl
`timescale 1ns / 1ps

module gdd_datapath (
  input  logic                         clk,
  input  gdd_pkg::gdd_cmd_t            cmd,
  input  logic [gdd_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [gdd_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [gdd_pkg::DAY_W-1:0]    in_start_day,
  input  logic [gdd_pkg::YEAR_W-1:0]   in_end_year,
  input  logic [gdd_pkg::MONTH_W-1:0]  in_end_month,
  input  logic [gdd_pkg::DAY_W-1:0]    in_end_day,
  output gdd_pkg::gdd_status_t         status,
  output logic signed [gdd_pkg::RES_W-1:0] out_day_difference
);
  import gdd_pkg::*;

  logic [YEAR_W-1:0]  y_r, y2_r;
  logic [MONTH_W-1:0] m1_r, m2_r;
  logic [DAY_W-1:0]   d1_r, d2_r;
  logic [R400_W-1:0]  c400_r;
  logic               leap_s_r, leap_e_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [RES_W-1:0] res_r;

  // year mod 400 by reciprocal multiply, one correction step
  function automatic logic [R400_W-1:0] r400_of(input logic [YEAR_W-1:0] y);
    logic [26:0] prod;
    logic [5:0]  q;
    logic [14:0] qm;
    logic [14:0] r;
    prod = 27'(y) * 27'(MOD_RECIP);
    q    = 6'(prod >> MOD_SHIFT);
    qm   = (15'(q) << 8) + (15'(q) << 7) + (15'(q) << 4);
    r    = 15'(y) - qm;
    if (r >= 15'(QUAD_CENTURY)) r = r - 15'(QUAD_CENTURY);
    return R400_W'(r);
  endfunction

  function automatic logic leap_from(input logic [R400_W-1:0] r, input logic [1:0] lo);
    return (lo == 2'd0) && (r != R400_W'(CENTURY)) && (r != R400_W'(2 * CENTURY))
           && (r != R400_W'(3 * CENTURY));
  endfunction

  logic [YEAR_W-1:0]  mod_y;
  logic [R400_W-1:0]  mod_r;
  logic               mod_leap, loop_leap;
  logic [DOY_W-1:0]   doy_s, doy_e;

  assign mod_y     = cmd.mod_e ? y2_r : y_r;
  assign mod_r     = r400_of(mod_y);
  assign mod_leap  = leap_from(mod_r, mod_y[1:0]);
  assign loop_leap = leap_from(c400_r, y_r[1:0]);

  assign doy_s = cum_days(m1_r) + DOY_W'(d1_r)
               + DOY_W'(leap_s_r && (m1_r > MONTH_W'(FEB_MONTH)));
  assign doy_e = cum_days(m2_r) + DOY_W'(d2_r)
               + DOY_W'(leap_e_r && (m2_r > MONTH_W'(FEB_MONTH)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r  <= in_start_year;
      m1_r <= in_start_month;
      d1_r <= in_start_day;
      y2_r <= in_end_year;
      m2_r <= in_end_month;
      d2_r <= in_end_day;
    end
    if (cmd.mod_s) begin
      c400_r   <= mod_r;
      leap_s_r <= mod_leap;
    end
    if (cmd.mod_e) leap_e_r <= mod_leap;
    if (cmd.init) acc_r <= $signed({{(ACC_W-DOY_W){1'b0}}, doy_e})
                         - $signed({{(ACC_W-DOY_W){1'b0}}, doy_s});
    if (cmd.step) begin
      acc_r  <= acc_r + ACC_W'(DAYS_PER_YEAR) + ACC_W'(loop_leap);
      y_r    <= y_r + YEAR_W'(1);
      c400_r <= (c400_r == R400_W'(QUAD_CENTURY - 1)) ? '0 : c400_r + R400_W'(1);
    end
    if (cmd.finish) res_r <= (acc_r > OUT_MAX) ? RES_W'(OUT_MAX) : acc_r[RES_W-1:0];
  end

  assign status.y_lt_end    = (y_r < y2_r);
  assign out_day_difference = res_r;

endmodule

// ===== rtl/core/gregorian_day_difference_top.sv =====
// gregorian_day_difference_top: signed Gregorian day count between two dates
// depends on gdd_pkg, gdd_ctrl and gdd_datapath
`timescale 1ns / 1ps

// A beat is taken when start is high while busy is low; busy then stays high
// until the result is ready. The result appears on out_day_difference for
// exactly one cycle with out_valid high, and the receiver cannot stall it, so
// it must be captured in that cycle. After acceptance, set-up states take the
// start year mod 400 and its leap flag, the end year leap flag and the
// day-of-year difference; the accumulator then adds one year per cycle while
// the end year is still ahead, and a finishing step saturates the result into
// a register before the strobe is shown.
// A new beat can be accepted in the cycle the strobe is shown.
module gregorian_day_difference_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [gdd_pkg::YEAR_W-1:0]       in_start_year,
  input  logic [gdd_pkg::MONTH_W-1:0]      in_start_month,
  input  logic [gdd_pkg::DAY_W-1:0]        in_start_day,
  input  logic [gdd_pkg::YEAR_W-1:0]       in_end_year,
  input  logic [gdd_pkg::MONTH_W-1:0]      in_end_month,
  input  logic [gdd_pkg::DAY_W-1:0]        in_end_day,
  output logic                             out_valid,
  output logic signed [gdd_pkg::RES_W-1:0] out_day_difference
);
  import gdd_pkg::*;

  // command and status between the sequencer and the datapath
  gdd_cmd_t    cmd;
  gdd_status_t status;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gdd_datapath u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .in_start_year      (in_start_year),
    .in_start_month     (in_start_month),
    .in_start_day       (in_start_day),
    .in_end_year        (in_end_year),
    .in_end_month       (in_end_month),
    .in_end_day         (in_end_day),
    .status             (status),
    .out_day_difference (out_day_difference)
  );

  // a strobe only follows the finishing step of the sequencer
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.finish))
    else $error("result strobe without a finishing step");

  // the year loop only advances while the end year is still ahead
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> status.y_lt_end)
    else $error("year step past the end year");

  // an accepted beat makes the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // one result per beat: strobes never come in adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule
